FILE: rtl/bounded_message_deque_top_defines.svh
// Assertion macros shared by the deque RTL files.
`ifndef BOUNDED_MESSAGE_DEQUE_TOP_DEFINES_SVH
`define BOUNDED_MESSAGE_DEQUE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BMD_ASSERT_NOW(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("deque check failed");
`define BMD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");
`else
`define BMD_ASSERT_NOW(lbl, expr)
`define BMD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/bmd_pkg.sv
// Types and constants of the bounded message deque.
package bmd_pkg;

    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 64;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int LIMIT_W    = 5;
    localparam int PORT_W     = 64;

    typedef enum logic [1:0] {
        ACT_PUSH_BACK  = 2'd0,
        ACT_PUSH_FRONT = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POLL       = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        action_t                 action;
        logic [WORD_WIDTH-1:0]   word;
    } req_t;

    typedef struct packed {
        status_t                 status;
        logic [WORD_WIDTH-1:0]   popped;
        logic                    readable;
        logic                    writable;
        logic                    event_pending;
        logic [CNT_W-1:0]        count;
    } res_t;

endpackage

FILE: rtl/bmd_core.sv
// Deque state, entry store and result register.
`include "bounded_message_deque_top_defines.svh"

module bmd_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    input  bmd_pkg::req_t           req,
    input  logic [bmd_pkg::LIMIT_W-1:0] fill_limit,
    output logic                    res_valid,
    output bmd_pkg::res_t           res
);
    import bmd_pkg::*;

    logic [WORD_WIDTH-1:0] store_mem [DEPTH];

    logic [PTR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             readable_reg, readable_next;
    logic             writable_reg, writable_next;
    logic             event_reg, event_next;
    logic             done_reg;
    res_t             res_reg, res_next;
    logic [WORD_WIDTH-1:0] popped_reg;

    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] count_dec;
    logic             is_push;
    logic             is_full;
    logic             wr_en;
    logic             pop_en;
    logic [PTR_W-1:0] wr_addr;

    always_comb
    begin
        if (fill_limit == '0 || fill_limit > LIMIT_W'(DEPTH))
        begin
            limit = CNT_W'(DEPTH);
        end
        else
        begin
            limit = CNT_W'(fill_limit);
        end
    end

    assign count_inc = count_reg + CNT_W'(1);
    assign count_dec = count_reg - CNT_W'(1);
    assign is_push   = (req.action == ACT_PUSH_BACK) || (req.action == ACT_PUSH_FRONT);
    assign is_full   = count_reg >= limit;

    always_comb
    begin
        front_next    = front_reg;
        count_next    = count_reg;
        readable_next = readable_reg;
        writable_next = writable_reg;
        event_next    = event_reg;
        wr_en         = 1'b0;
        pop_en        = 1'b0;
        wr_addr       = front_reg + count_reg[PTR_W-1:0];
        res_next      = '0;
        res_next.status = ST_DONE;
        if (req_valid)
        begin
            case (req.action)
                ACT_PUSH_BACK, ACT_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        res_next.status = ST_FULL;
                    end
                    else
                    begin
                        if (!readable_reg)
                        begin
                            event_next = 1'b1;
                        end
                        readable_next = 1'b1;
                        if (count_inc >= limit)
                        begin
                            writable_next = 1'b0;
                        end
                        if (req.action == ACT_PUSH_FRONT)
                        begin
                            front_next = front_reg - PTR_W'(1);
                            wr_addr    = front_reg - PTR_W'(1);
                        end
                        wr_en      = 1'b1;
                        count_next = count_inc;
                    end
                end
                ACT_POP_FRONT:
                begin
                    if (count_reg == '0)
                    begin
                        res_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        if (!writable_reg && count_dec < limit)
                        begin
                            writable_next = 1'b1;
                            event_next    = 1'b1;
                        end
                        if (count_dec == '0)
                        begin
                            readable_next = 1'b0;
                        end
                        pop_en          = 1'b1;
                        front_next      = front_reg + PTR_W'(1);
                        count_next      = count_dec;
                    end
                end
                ACT_POLL:
                begin
                    event_next = 1'b0;
                end
                default:
                begin
                    event_next = event_reg;
                end
            endcase
        end
        res_next.readable      = readable_next;
        res_next.writable      = writable_next;
        res_next.event_pending = event_next;
        res_next.count         = count_next;
    end

    // hold the entry store; write one slot per accepted push, read the front on a pop
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= req.word;
        end
        popped_reg <= pop_en ? store_mem[front_reg] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg    <= '0;
            count_reg    <= '0;
            readable_reg <= 1'b0;
            writable_reg <= 1'b1;
            event_reg    <= 1'b1;
            done_reg     <= 1'b0;
        end
        else
        begin
            front_reg    <= front_next;
            count_reg    <= count_next;
            readable_reg <= readable_next;
            writable_reg <= writable_next;
            event_reg    <= event_next;
            done_reg     <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = done_reg;

    always_comb
    begin
        res        = res_reg;
        res.popped = popped_reg;
    end

    `BMD_ASSERT_NOW(a_count_bound, count_reg <= CNT_W'(DEPTH))
    `BMD_ASSERT_NOW(a_readable_tracks_count, readable_reg == (count_reg != '0))
    `BMD_ASSERT_NEXT(a_refused_push_keeps_state, req_valid && is_push && is_full,
        count_reg == $past(count_reg) && front_reg == $past(front_reg))
    `BMD_ASSERT_NEXT(a_result_follows_request, req_valid,
        done_reg && res_reg.count == count_reg)

endmodule

FILE: rtl/bounded_message_deque_top.sv
// Top level of the bounded message deque: request and limit registers.
//
//  channel   direction  handshake                payload
//  request   in         start (busy low)         action, message_word
//  result    out        done, one-cycle strobe   status, popped_word, readable_flag,
//                                                writable_flag, event_pending, entry_count
//  limit     in         fill_limit_we            fill_limit
//
// One request per cycle; done strobes after the request and core result registers.
// Throughput is set by the single execute stage that updates the deque state.
// busy stays low: the receiver cannot stall, so no request is ever held off.
// Reset clears the deque to empty, readable 0, writable 1, event pending 1, limit 0.
`include "bounded_message_deque_top_defines.svh"

module bounded_message_deque_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  action,
    input  logic [bmd_pkg::PORT_W-1:0]  message_word,
    input  logic                        fill_limit_we,
    input  logic [bmd_pkg::LIMIT_W-1:0] fill_limit,
    output logic                        done,
    output logic [1:0]                  status,
    output logic [bmd_pkg::PORT_W-1:0]  popped_word,
    output logic                        readable_flag,
    output logic                        writable_flag,
    output logic                        event_pending,
    output logic [bmd_pkg::CNT_W-1:0]   entry_count
);
    import bmd_pkg::*;

    logic               req_valid_reg;
    req_t               req_reg, req_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic               res_valid;
    res_t               res;
    logic               accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        req_next.action = action_t'(action);
        req_next.word   = message_word[WORD_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            limit_reg     <= '0;
        end
        else
        begin
            req_valid_reg <= accept;
            if (fill_limit_we)
            begin
                limit_reg <= fill_limit;
            end
        end
    end

    // capture the request payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_next;
        end
    end

    bmd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid_reg),
        .req        (req_reg),
        .fill_limit (limit_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign done          = res_valid;
    assign status        = res.status;
    assign popped_word   = PORT_W'(res.popped);
    assign readable_flag = res.readable;
    assign writable_flag = res.writable;
    assign event_pending = res.event_pending;
    assign entry_count   = res.count;

    `BMD_ASSERT_NEXT(a_accept_reaches_core, accept, req_valid_reg)
    `BMD_ASSERT_NEXT(a_done_two_after_start, accept, ##1 done)
    `BMD_ASSERT_NOW(a_status_legal, !done || status != 2'd3)

endmodule

FILE: dv/bmd_result_checker.sv
// Checker for the bounded message deque: tracks requests, predicts results and compares them.
`timescale 1ns / 1ps

module bmd_result_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [1:0]                  action,
    input  logic [bmd_pkg::PORT_W-1:0]  message_word,
    input  logic                        fill_limit_we,
    input  logic [bmd_pkg::LIMIT_W-1:0] fill_limit,
    input  logic                        done,
    input  logic [1:0]                  status,
    input  logic [bmd_pkg::PORT_W-1:0]  popped_word,
    input  logic                        readable_flag,
    input  logic                        writable_flag,
    input  logic                        event_pending,
    input  logic [bmd_pkg::CNT_W-1:0]   entry_count,
    output int                          fail_count,
    output int                          pending
);
    import bmd_pkg::*;

    logic [WORD_WIDTH-1:0] word_ring [DEPTH];
    logic [PTR_W-1:0]      head_idx;
    logic [CNT_W-1:0]      held;
    logic                  readable_q;
    logic                  writable_q;
    logic                  event_q;
    logic [LIMIT_W-1:0]    limit_reg;
    res_t                  outcome_q [$];

    function automatic int cap_entries();
        if (limit_reg == 0 || limit_reg > DEPTH)
            return DEPTH;
        return int'(limit_reg);
    endfunction

    function automatic res_t apply_request(action_t act, logic [WORD_WIDTH-1:0] w);
        res_t             r;
        int               lim;
        logic [PTR_W-1:0] slot;
        lim = cap_entries();
        r = '0;
        r.status = ST_DONE;
        case (act)
            ACT_PUSH_BACK, ACT_PUSH_FRONT:
            begin
                if (held >= lim)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    if (!readable_q)
                    begin
                        readable_q = 1'b1;
                        event_q = 1'b1;
                    end
                    if (writable_q && int'(held) + 1 >= lim)
                        writable_q = 1'b0;
                    if (act == ACT_PUSH_BACK)
                    begin
                        slot = head_idx + held[PTR_W-1:0];
                    end
                    else
                    begin
                        head_idx = head_idx - 1'b1;
                        slot = head_idx;
                    end
                    word_ring[slot] = w;
                    held = held + 1'b1;
                end
            end
            ACT_POP_FRONT:
            begin
                if (held == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    if (!writable_q && int'(held) - 1 < lim)
                    begin
                        writable_q = 1'b1;
                        event_q = 1'b1;
                    end
                    if (held == 1)
                        readable_q = 1'b0;
                    r.popped = word_ring[head_idx];
                    head_idx = head_idx + 1'b1;
                    held = held - 1'b1;
                end
            end
            default:
            begin
                event_q = 1'b0;
            end
        endcase
        r.readable = readable_q;
        r.writable = writable_q;
        r.event_pending = event_q;
        r.count = held;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        res_t want;
        if (!rst_n)
        begin
            head_idx = '0;
            held = '0;
            readable_q = 1'b0;
            writable_q = 1'b1;
            event_q = 1'b1;
            limit_reg = '0;
            outcome_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("result strobe with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                    if (popped_word !== want.popped)
                    begin
                        $error("popped_word: expected %h, got %h", want.popped, popped_word);
                        fail_count++;
                    end
                    if (readable_flag !== want.readable)
                    begin
                        $error("readable_flag: expected %0b, got %0b",
                               want.readable, readable_flag);
                        fail_count++;
                    end
                    if (writable_flag !== want.writable)
                    begin
                        $error("writable_flag: expected %0b, got %0b",
                               want.writable, writable_flag);
                        fail_count++;
                    end
                    if (event_pending !== want.event_pending)
                    begin
                        $error("event_pending: expected %0b, got %0b",
                               want.event_pending, event_pending);
                        fail_count++;
                    end
                    if (entry_count !== want.count)
                    begin
                        $error("entry_count: expected %0d, got %0d", want.count, entry_count);
                        fail_count++;
                    end
                end
            end
            if (fill_limit_we)
                limit_reg = fill_limit;
            if (start && !busy)
                outcome_q.push_back(apply_request(action_t'(action), message_word));
        end
        pending = outcome_q.size();
    end

endmodule

FILE: dv/bounded_message_deque_top_tb.sv
// Testbench top for the bounded message deque: drives requests and limit writes, gives the verdict.
`timescale 1ns / 1ps

module bounded_message_deque_top_tb;
    import bmd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            action;
    logic [PORT_W-1:0]     message_word;
    logic                  fill_limit_we;
    logic [LIMIT_W-1:0]    fill_limit;
    logic                  done;
    logic [1:0]            status;
    logic [PORT_W-1:0]     popped_word;
    logic                  readable_flag;
    logic                  writable_flag;
    logic                  event_pending;
    logic [CNT_W-1:0]      entry_count;
    int                    fail_count;
    int                    pending;
    int                    cycles;
    bit                    idle_en;

    bounded_message_deque_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .message_word  (message_word),
        .fill_limit_we (fill_limit_we),
        .fill_limit    (fill_limit),
        .done          (done),
        .status        (status),
        .popped_word   (popped_word),
        .readable_flag (readable_flag),
        .writable_flag (writable_flag),
        .event_pending (event_pending),
        .entry_count   (entry_count)
    );

    bmd_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .message_word  (message_word),
        .fill_limit_we (fill_limit_we),
        .fill_limit    (fill_limit),
        .done          (done),
        .status        (status),
        .popped_word   (popped_word),
        .readable_flag (readable_flag),
        .writable_flag (writable_flag),
        .event_pending (event_pending),
        .entry_count   (entry_count),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_request(input action_t act, input logic [PORT_W-1:0] w);
        bit taken;
        @(negedge clk);
        while (idle_en && $urandom_range(99) < 23)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        action <= act;
        message_word <= w;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
        end
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        fill_limit_we <= 1'b1;
        fill_limit <= v;
        @(negedge clk);
        fill_limit_we <= 1'b0;
    endtask

    task automatic random_run(input int n, input int push_pct);
        int                r;
        logic [PORT_W-1:0] w;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            case ($urandom_range(9))
                0:       w = '0;
                1:       w = '1;
                default: w = {$urandom(), $urandom()};
            endcase
            if (r < 8)
                send_request(ACT_POLL, w);
            else if (r < 8 + push_pct * 92 / 100)
                send_request($urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, w);
            else
                send_request(ACT_POP_FRONT, w);
        end
    endtask

    initial
    begin : stimulus
        logic [LIMIT_W-1:0] phase_limits [13];
        int                 sent;
        int                 run_len;
        int                 bias;
        phase_limits = '{5'd16, 5'd3, 5'd31, 5'd0, 5'd5, 5'd17, 5'd1,
                         5'd12, 5'd2, 5'd20, 5'd16, 5'd7, 5'd0};
        idle_en = 1'b1;
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_PUSH_BACK;
        message_word = '0;
        fill_limit_we = 1'b0;
        fill_limit = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_request(ACT_POLL, 64'h0);
        send_request(ACT_POP_FRONT, '1);
        send_request(ACT_PUSH_BACK, 64'h0);
        send_request(ACT_PUSH_BACK, '1);
        send_request(ACT_PUSH_FRONT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(ACT_POLL, 64'h5555_5555_5555_5555);
        send_request(ACT_POP_FRONT, 64'h0);
        send_request(ACT_POP_FRONT, 64'h0);
        send_request(ACT_POP_FRONT, 64'h0);
        send_request(ACT_POP_FRONT, 64'h0);
        send_request(ACT_POLL, 64'h0);

        write_limit(5'd1);
        send_request(ACT_PUSH_BACK, 64'h5555_5555_5555_5555);
        send_request(ACT_PUSH_FRONT, 64'h1234_5678_9ABC_DEF0);
        send_request(ACT_POLL, 64'h0);
        send_request(ACT_POP_FRONT, 64'h0);
        send_request(ACT_POLL, 64'h0);

        write_limit(5'd2);
        send_request(ACT_PUSH_FRONT, 64'h8000_0000_0000_0001);
        send_request(ACT_PUSH_FRONT, 64'h7FFF_FFFF_FFFF_FFFE);
        send_request(ACT_PUSH_BACK, '1);
        send_request(ACT_POP_FRONT, 64'h0);
        send_request(ACT_POP_FRONT, 64'h0);

        foreach (phase_limits[p])
        begin
            idle_en = !(p inside {[4:6]});
            write_limit(phase_limits[p]);
            sent = 0;
            while (sent < 108)
            begin
                run_len = $urandom_range(24, 4);
                if (run_len > 108 - sent)
                    run_len = 108 - sent;
                case ($urandom_range(2))
                    0:       bias = 80;
                    1:       bias = 20;
                    default: bias = 50;
                endcase
                random_run(run_len, bias);
                sent += run_len;
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
